/* sv/xmlu8_pkg.sv */
// Shared types and constants for the XML-escaping UTF-8 encoder.
// Used by xmlu8_map and xml_escape_utf8_encoder; no dependencies.
package xmlu8_pkg;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned NBYTES  = 6;

    // Characters replaced by entities
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    // Range limits and UTF-8 framing
    localparam logic [UNIT_W-1:0] LIM_ONE = 16'h0080;
    localparam logic [UNIT_W-1:0] LIM_TWO = 16'h0800;
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [5:0] CONT_MASK  = 6'h3F;

    // Encoded bytes for one code unit, slot 0 first
    typedef struct packed {
        logic [CNT_W-1:0]         count;
        logic [NBYTES-1:0][7:0]   bytes;
    } t_enc;

    // Entity texts, slot 0 in the low byte
    localparam t_enc ENT_AMP  = '{count: 3'd5,
        bytes: {8'h00, 8'h3B, 8'h70, 8'h6D, 8'h61, 8'h26}};
    localparam t_enc ENT_QUOT = '{count: 3'd6,
        bytes: {8'h3B, 8'h74, 8'h6F, 8'h75, 8'h71, 8'h26}};
    localparam t_enc ENT_LT   = '{count: 3'd4,
        bytes: {8'h00, 8'h00, 8'h3B, 8'h74, 8'h6C, 8'h26}};
    localparam t_enc ENT_GT   = '{count: 3'd4,
        bytes: {8'h00, 8'h00, 8'h3B, 8'h74, 8'h67, 8'h26}};

endpackage

/* sv/xmlu8_map.sv */
// Combinational mapping of one 16-bit code unit to escaped UTF-8 bytes.
// Depends on xmlu8_pkg.
module xmlu8_map (
    input  logic [xmlu8_pkg::UNIT_W-1:0] i_unit,
    output xmlu8_pkg::t_enc              o_enc
);
    import xmlu8_pkg::*;

    always_comb begin
        o_enc = '0;
        if (i_unit < LIM_ONE) begin
            case (i_unit[7:0])
                CH_AMP:  o_enc = ENT_AMP;
                CH_QUOT: o_enc = ENT_QUOT;
                CH_LT:   o_enc = ENT_LT;
                CH_GT:   o_enc = ENT_GT;
                default: begin
                    o_enc.count    = 3'd1;
                    o_enc.bytes[0] = i_unit[7:0];
                end
            endcase
        end else if (i_unit < LIM_TWO) begin
            o_enc.count    = 3'd2;
            o_enc.bytes[0] = LEAD_TWO | {3'b000, i_unit[10:6]};
            o_enc.bytes[1] = CONT_MARK | {2'b00, i_unit[5:0] & CONT_MASK};
        end else begin
            // surrogates land here too, one three-byte sequence each
            o_enc.count    = 3'd3;
            o_enc.bytes[0] = LEAD_THREE | {4'b0000, i_unit[15:12]};
            o_enc.bytes[1] = CONT_MARK | {2'b00, i_unit[11:6] & CONT_MASK};
            o_enc.bytes[2] = CONT_MARK | {2'b00, i_unit[5:0] & CONT_MASK};
        end
    end

endmodule

/* sv/xml_escape_utf8_encoder.sv */
// UTF-8 encoder with XML entity escaping, one code unit per beat.
// A beat passes through the input reg, then the result reg, before result valid.
// Throughput: one beat per cycle while i_ready stays high; the mapping sits between the two registers.
// Reset (i_rst_n low, synchronous) empties both stages; payload is not reset.
// Depends on xmlu8_pkg and xmlu8_map.
module xml_escape_utf8_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [xmlu8_pkg::UNIT_W-1:0]  i_code_unit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [xmlu8_pkg::CNT_W-1:0]   o_byte_count,
    output logic [7:0]                    o_byte_0,
    output logic [7:0]                    o_byte_1,
    output logic [7:0]                    o_byte_2,
    output logic [7:0]                    o_byte_3,
    output logic [7:0]                    o_byte_4,
    output logic [7:0]                    o_byte_5
);
    import xmlu8_pkg::*;

    logic              r_in_vld;
    logic [UNIT_W-1:0] r_in_unit;
    logic              r_out_vld;
    t_enc              r_out;
    t_enc              w_enc;
    logic              w_adv;

    // advance stage 1 into the result register when it is free or draining
    assign w_adv   = !r_out_vld || i_ready;
    assign o_ready = !r_in_vld || w_adv;

    xmlu8_map u_map (
        .i_unit (r_in_unit),
        .o_enc  (w_enc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_unit <= i_code_unit;
        end
        if (w_adv && r_in_vld) begin
            r_out <= w_enc;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_byte_count = r_out.count;
    assign o_byte_0     = r_out.bytes[0];
    assign o_byte_1     = r_out.bytes[1];
    assign o_byte_2     = r_out.bytes[2];
    assign o_byte_3     = r_out.bytes[3];
    assign o_byte_4     = r_out.bytes[4];
    assign o_byte_5     = r_out.bytes[5];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_count != 3'd0) && (o_byte_count <= 3'd6))
        else $error("byte count out of range");

    a_single_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_byte_count == 3'd1) |->
            (o_byte_1 == 8'h00) && (o_byte_2 == 8'h00) && (o_byte_3 == 8'h00)
            && (o_byte_4 == 8'h00) && (o_byte_5 == 8'h00))
        else $error("unused byte slot not zero");

    a_three_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_byte_0[7:4] == 4'hE) |-> (o_byte_count == 3'd3))
        else $error("three-byte lead with wrong count");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && w_adv |=> o_valid)
        else $error("stage 1 beat lost on advance");

endmodule

/* sim/testbench.sv */
// Testbench for xml_escape_utf8_encoder: drives code units, predicts the escaped
// UTF-8 bytes of each one and checks every result beat in order.
// Depends on xmlu8_pkg and the encoder RTL.
`timescale 1ns / 100ps

module testbench;

    import xmlu8_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 10;

    typedef struct packed {
        logic [CNT_W-1:0]       nbytes;
        logic [NBYTES-1:0][7:0] octets;
    } t_utf8_out;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        t_utf8_out         enc;
    } t_pending;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [UNIT_W-1:0] i_code_unit = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [CNT_W-1:0]  o_byte_count;
    logic [7:0]        o_byte_0, o_byte_1, o_byte_2, o_byte_3, o_byte_4, o_byte_5;

    t_pending pending_enc[$];
    int       mismatch_count = 0;
    int       idle_count = 0;
    bit       tx_gaps_on = 1'b0;
    bit       rx_stalls_on = 1'b0;
    int       rx_hold_len = 0;
    int       rx_hold_left = 0;
    int       rx_stall_left = 0;

    xml_escape_utf8_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_code_unit  (i_code_unit),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_byte_count (o_byte_count),
        .o_byte_0     (o_byte_0),
        .o_byte_1     (o_byte_1),
        .o_byte_2     (o_byte_2),
        .o_byte_3     (o_byte_3),
        .o_byte_4     (o_byte_4),
        .o_byte_5     (o_byte_5)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_utf8_out encode_unit(input logic [UNIT_W-1:0] u);
        t_utf8_out r;
        string     ent;
        r = '0;
        ent = "";
        if (u < LIM_ONE) begin
            case (u[7:0])
                CH_AMP:  ent = "&amp;";
                CH_QUOT: ent = "&quot;";
                CH_LT:   ent = "&lt;";
                CH_GT:   ent = "&gt;";
                default: ent = "";
            endcase
            if (ent.len() != 0) begin
                r.nbytes = CNT_W'(ent.len());
                for (int i = 0; i < ent.len(); i++) begin
                    r.octets[i] = ent[i];
                end
            end else begin
                r.nbytes    = 3'd1;
                r.octets[0] = u[7:0];
            end
        end else if (u < LIM_TWO) begin
            r.nbytes    = 3'd2;
            r.octets[0] = {3'b110, u[10:6]};
            r.octets[1] = {2'b10, u[5:0]};
        end else begin
            r.nbytes    = 3'd3;
            r.octets[0] = {4'b1110, u[15:12]};
            r.octets[1] = {2'b10, u[11:6]};
            r.octets[2] = {2'b10, u[5:0]};
        end
        return r;
    endfunction

    task automatic note_mismatch(input logic [UNIT_W-1:0] unit, input string field,
                                 input logic [7:0] exp_val, input logic [7:0] act_val);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch for unit %h, %s: expected %h, got %h",
                     unit, field, exp_val, act_val);
        end
    endtask

    // Record accepted input beats, then check result beats against the oldest one.
    always @(posedge i_clk) begin
        t_pending           head;
        logic [5:0][7:0]    got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                pending_enc.push_back('{unit: i_code_unit, enc: encode_unit(i_code_unit)});
            end
            if (o_valid && i_ready) begin
                got = {o_byte_5, o_byte_4, o_byte_3, o_byte_2, o_byte_1, o_byte_0};
                if (pending_enc.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result beat: count %0d bytes %h", o_byte_count, got);
                    end
                end else begin
                    head = pending_enc.pop_front();
                    if (o_byte_count !== head.enc.nbytes) begin
                        note_mismatch(head.unit, "byte_count", 8'(head.enc.nbytes),
                                      8'(o_byte_count));
                    end
                    for (int i = 0; i < NBYTES; i++) begin
                        if (got[i] !== head.enc.octets[i]) begin
                            note_mismatch(head.unit, $sformatf("byte_%0d", i),
                                          head.enc.octets[i], got[i]);
                        end
                    end
                end
            end
        end
    end

    // Receiver: a long hold-off on request, random stall bursts when enabled.
    always @(posedge i_clk) begin
        if (rx_hold_len > 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(1, 7) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_count = 0;
        end else begin
            idle_count++;
        end
        if (idle_count >= STALL_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Keep valid high across back-to-back beats; drop it only for a gap.
    task automatic send_unit(input logic [UNIT_W-1:0] u);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= u;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and let the monitor queue the last accepted beat before waiting for the queue to empty.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_enc.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [UNIT_W-1:0] pick_unit();
        logic [UNIT_W-1:0] u;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       u = {8'h00, CH_AMP};
                    1:       u = {8'h00, CH_QUOT};
                    2:       u = {8'h00, CH_LT};
                    default: u = {8'h00, CH_GT};
                endcase
            end
            1, 2:    u = UNIT_W'($urandom_range(0, 16'h007F));
            3, 4:    u = UNIT_W'($urandom_range(16'h0080, 16'h07FF));
            5:       u = UNIT_W'($urandom_range(16'hD800, 16'hDFFF));
            6: begin
                case ($urandom_range(0, 5))
                    0:       u = 16'h0000;
                    1:       u = 16'h007F;
                    2:       u = 16'h0080;
                    3:       u = 16'h07FF;
                    4:       u = 16'h0800;
                    default: u = 16'hFFFF;
                endcase
            end
            default: u = UNIT_W'($urandom_range(0, 16'hFFFF));
        endcase
        return u;
    endfunction

    task automatic test_directed();
        logic [UNIT_W-1:0] units[$];
        units = '{16'h0000, {8'h00, CH_AMP}, {8'h00, CH_QUOT}, {8'h00, CH_LT},
                  {8'h00, CH_GT}, 16'h0001, 16'h0025, 16'h0027, 16'h003D, 16'h0041,
                  16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD800, 16'hDBFF,
                  16'hDC00, 16'hDFFF, 16'hFFFF, 16'hAAAA, 16'h5555};
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        foreach (units[i]) send_unit(units[i]);
    endtask

    // Hold the receiver off while the sender keeps offering beats.
    task automatic test_backpressure();
        tx_gaps_on  = 1'b0;
        rx_hold_len = 300;
        repeat (30) send_unit(pick_unit());
    endtask

    // Pause the sender until every result is back, then resume.
    task automatic test_drain_pause();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        repeat (20) send_unit(pick_unit());
        wait_for_drain();
        repeat (20) send_unit(pick_unit());
    endtask

    task automatic test_random(input int count, input bit with_idle);
        tx_gaps_on   = with_idle;
        rx_stalls_on = with_idle;
        repeat (count) send_unit(pick_unit());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(560, 1'b1);
        test_random(150, 1'b0);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_enc.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
sv/xmlu8_pkg.sv
sv/xmlu8_map.sv
sv/xml_escape_utf8_encoder.sv
sim/testbench.sv
